// ===== rtl/core/bez_pkg.sv =====
// Shared types and constants for the cubic Bezier point evaluator.
// No dependencies.
package bez_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_IDX_BITS = 3;
	localparam int NUM_CTRL_PTS = 4;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_P0_X = 3'd0,
		REG_P0_Y = 3'd1,
		REG_P1_X = 3'd2,
		REG_P1_Y = 3'd3,
		REG_P2_X = 3'd4,
		REG_P2_Y = 3'd5,
		REG_P3_X = 3'd6,
		REG_P3_Y = 3'd7
	} cfg_reg_t;

endpackage

// ===== rtl/core/cubic_bezier_point_eval.sv =====
// Cubic Bezier point evaluator, de Casteljau scheme, as a row of three lerp cells.
// A word taken with start is registered in u_cell1, u_cell2 and u_cell3 in turn; done comes from u_cell3.
// Throughput: one t word per cycle, set by the three-cell pipeline, one level per cell.
// busy stays low, and the receiver cannot stall: each result shows on x_pixel/y_pixel with
// done for one cycle.
// Reset (arst_n low, asynchronous) drops words in flight and clears the control points to 0.
module cubic_bezier_point_eval
	import bez_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int T_FRAC_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [T_FRAC_BITS:0]    t_fraction,
	output logic                    done,
	output logic [COORD_BITS-1:0]   x_pixel,
	output logic [COORD_BITS-1:0]   y_pixel,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_addr,
	input  logic [COORD_BITS-1:0]   cfg_wdata
);

	localparam int PW = COORD_BITS + T_FRAC_BITS;
	localparam int TW = T_FRAC_BITS + 1;
	localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

	logic [COORD_BITS-1:0] cp_q [NUM_REGS];

	logic          in_valid;
	logic [TW-1:0] t_sat;
	logic [PW-1:0] x_s0 [NUM_CTRL_PTS];
	logic [PW-1:0] y_s0 [NUM_CTRL_PTS];

	logic          valid_s1, valid_s2, valid_s3;
	logic [TW-1:0] t_s1, t_s2, t_s3;
	logic [PW-1:0] x_s1 [3];
	logic [PW-1:0] y_s1 [3];
	logic [PW-1:0] x_s2 [2];
	logic [PW-1:0] y_s2 [2];
	logic [PW-1:0] x_s3 [1];
	logic [PW-1:0] y_s3 [1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cp_q[i] <= '0;
			end
		end else if (cfg_we) begin
			cp_q[cfg_addr] <= cfg_wdata;
		end
	end

	assign busy     = 1'b0;
	assign in_valid = start && !busy;
	// clamp t above one to one
	assign t_sat    = (t_fraction > T_ONE) ? T_ONE : t_fraction;

	assign x_s0[0] = {cp_q[REG_P0_X], {T_FRAC_BITS{1'b0}}};
	assign x_s0[1] = {cp_q[REG_P1_X], {T_FRAC_BITS{1'b0}}};
	assign x_s0[2] = {cp_q[REG_P2_X], {T_FRAC_BITS{1'b0}}};
	assign x_s0[3] = {cp_q[REG_P3_X], {T_FRAC_BITS{1'b0}}};
	assign y_s0[0] = {cp_q[REG_P0_Y], {T_FRAC_BITS{1'b0}}};
	assign y_s0[1] = {cp_q[REG_P1_Y], {T_FRAC_BITS{1'b0}}};
	assign y_s0[2] = {cp_q[REG_P2_Y], {T_FRAC_BITS{1'b0}}};
	assign y_s0[3] = {cp_q[REG_P3_Y], {T_FRAC_BITS{1'b0}}};

	bez_cell #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS), .NPTS(4)) u_cell1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_t(t_sat), .in_x(x_s0), .in_y(y_s0),
		.out_valid(valid_s1), .out_t(t_s1), .out_x(x_s1), .out_y(y_s1)
	);

	bez_cell #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS), .NPTS(3)) u_cell2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s1), .in_t(t_s1), .in_x(x_s1), .in_y(y_s1),
		.out_valid(valid_s2), .out_t(t_s2), .out_x(x_s2), .out_y(y_s2)
	);

	bez_cell #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS), .NPTS(2)) u_cell3 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s2), .in_t(t_s2), .in_x(x_s2), .in_y(y_s2),
		.out_valid(valid_s3), .out_t(t_s3), .out_x(x_s3), .out_y(y_s3)
	);

	// drop the fraction: truncate to whole pixels
	assign done    = valid_s3;
	assign x_pixel = x_s3[0][T_FRAC_BITS +: COORD_BITS];
	assign y_pixel = y_s3[0][T_FRAC_BITS +: COORD_BITS];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##3 done)
		else $error("accepted word did not complete in three cycles");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_valid, 3))
		else $error("result without an accepted word");

	a_t_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (t_s1 <= T_ONE) && (t_s2 == $past(t_s1)))
		else $error("t left the clamp or lost step along the row");

	a_t_carried: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> t_s3 == $past(t_s2))
		else $error("t lost step at the last cell");

endmodule

// ===== rtl/core/bez_cell.sv =====
// One de Casteljau level: NPTS points per axis in, NPTS-1 rounded lerps out, registered.
// Cells chain into a row; each hands its points, t and valid to the next every cycle.
module bez_cell #(
	parameter int COORD_BITS = 10,
	parameter int T_FRAC_BITS = 10,
	parameter int NPTS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [T_FRAC_BITS:0]              in_t,
	input  logic [COORD_BITS+T_FRAC_BITS-1:0] in_x [NPTS],
	input  logic [COORD_BITS+T_FRAC_BITS-1:0] in_y [NPTS],
	output logic                              out_valid,
	output logic [T_FRAC_BITS:0]              out_t,
	output logic [COORD_BITS+T_FRAC_BITS-1:0] out_x [NPTS-1],
	output logic [COORD_BITS+T_FRAC_BITS-1:0] out_y [NPTS-1]
);

	localparam int PW = COORD_BITS + T_FRAC_BITS;
	localparam int TW = T_FRAC_BITS + 1;
	localparam int NO = NPTS - 1;
	localparam int MW = PW + TW + 2;
	localparam logic [MW-1:0] HALF = MW'(1) << (T_FRAC_BITS - 1);

	logic          valid_q;
	logic [TW-1:0] t_q;
	logic [PW-1:0] x_q [NO];
	logic [PW-1:0] y_q [NO];
	logic [PW-1:0] x_nxt [NO];
	logic [PW-1:0] y_nxt [NO];

	// a*ONE + t*(b-a) + HALF equals (ONE-t)*a + t*b + HALF: one multiply per lerp
	function automatic logic [PW-1:0] lerp(input logic [PW-1:0] a, input logic [PW-1:0] b,
		input logic [TW-1:0] t);
		logic signed [PW:0]   diff;
		logic signed [MW-1:0] acc;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		acc = $signed(MW'({a, {T_FRAC_BITS{1'b0}}})) + diff * $signed({1'b0, t})
			+ $signed(HALF);
		return acc[T_FRAC_BITS +: PW];
	endfunction

	always_comb begin
		for (int i = 0; i < NO; i++) begin
			x_nxt[i] = lerp(in_x[i], in_x[i+1], in_t);
			y_nxt[i] = lerp(in_y[i], in_y[i+1], in_t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		t_q <= in_t;
		x_q <= x_nxt;
		y_q <= y_nxt;
	end

	assign out_valid = valid_q;
	assign out_t     = t_q;
	assign out_x     = x_q;
	assign out_y     = y_q;

endmodule
